// ----- hw/rtl/polynomial_store_horner_eval_unit_assert.svh -----
// Assertion macros shared by the RTL.
`ifndef POLYNOMIAL_STORE_HORNER_EVAL_UNIT_ASSERT_SVH
`define POLYNOMIAL_STORE_HORNER_EVAL_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PSHE_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pshe assertion failed");

// Next-cycle implication.
`define PSHE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pshe assertion failed");

`endif

// ----- hw/rtl/pshe_pkg.sv -----
`default_nettype none
package pshe_pkg;

  localparam int NUM_POLYS_DEF        = 16;
  localparam int MAX_DEGREE_TERMS_DEF = 64;
  localparam int FRAC_BITS_DEF        = 16;

  localparam logic [4:0] POLYS_IN_USE_RST = 5'd16;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_EVAL   = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  // classified operations
  localparam logic [2:0] OP_NOP  = 3'd0;
  localparam logic [2:0] OP_INS  = 3'd1;
  localparam logic [2:0] OP_EVAL = 3'd2;
  localparam logic [2:0] OP_QRY  = 3'd3;
  localparam logic [2:0] OP_OOR  = 3'd4;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0]         op;
    logic [3:0]         slot;
    logic               exp_ok;
    logic [5:0]         exp;
    logic signed [15:0] coef;
    logic signed [31:0] point;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/pshe_front.sv -----
`default_nettype none
module pshe_front #(
  parameter int NUM_POLYS        = 16,
  parameter int MAX_DEGREE_TERMS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire logic [1:0]           in_mode,
  input  wire logic [3:0]           in_poly_index,
  input  wire logic [5:0]           in_exponent,
  input  wire logic signed [15:0]   in_term_coefficient,
  input  wire logic signed [31:0]   in_point,
  input  wire logic                 cfg_we,
  input  wire logic [4:0]           cfg_wdata,
  output logic                      push,
  output pshe_pkg::cmd_t            push_word
);
  import pshe_pkg::*;

  logic [4:0] polys_in_use_r;
  logic       in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      polys_in_use_r <= POLYS_IN_USE_RST;
    end else if (cfg_we) begin
      polys_in_use_r <= cfg_wdata;
    end
  end

  assign in_range = ({1'b0, in_poly_index} < polys_in_use_r) &&
                    (32'(in_poly_index) < 32'(NUM_POLYS));

  always_comb begin
    push_word.slot   = in_poly_index;
    push_word.exp    = in_exponent;
    push_word.exp_ok = 32'(in_exponent) < 32'(MAX_DEGREE_TERMS);
    push_word.coef   = in_term_coefficient;
    push_word.point  = in_point;
    case (in_mode)
      MODE_INSERT: push_word.op = in_range ? OP_INS  : OP_OOR;
      MODE_EVAL:   push_word.op = in_range ? OP_EVAL : OP_OOR;
      MODE_QUERY:  push_word.op = in_range ? OP_QRY  : OP_OOR;
      default:     push_word.op = OP_NOP;
    endcase
  end

  assign push = start && !busy;

endmodule
`default_nettype wire

// ----- hw/rtl/pshe_queue.sv -----
`default_nettype none
module pshe_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire pshe_pkg::cmd_t    push_word,
  input  wire logic              pop,
  output pshe_pkg::cmd_t         head,
  output pshe_pkg::q_stat_t      stat
);
  import pshe_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign head       = slots_r[rd_ptr_r];
  assign stat.full  = 32'(count_r) == QUEUE_DEPTH;
  assign stat.empty = count_r == '0;

endmodule
`default_nettype wire

// ----- hw/rtl/pshe_back.sv -----
`default_nettype none
module pshe_back #(
  parameter int NUM_POLYS        = 16,
  parameter int MAX_DEGREE_TERMS = 64,
  parameter int FRAC_BITS        = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pshe_pkg::cmd_t       head,
  input  wire logic                 q_empty,
  output logic                      pop,
  output pshe_pkg::back_stat_t      stat,
  output logic                      out_valid,
  output logic signed [63:0]        out_value,
  output logic signed [15:0]        out_coefficient_out,
  output logic [1:0]                out_status
);
  import pshe_pkg::*;

  localparam int STORE_DEPTH = NUM_POLYS * MAX_DEGREE_TERMS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SLOT_W      = (NUM_POLYS > 1) ? $clog2(NUM_POLYS) : 1;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd6;
  localparam logic [3:0] S_QRY   = 4'd7;
  localparam logic [3:0] S_QOUT  = 4'd8;

  localparam logic signed [63:0] I64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] I64_MIN = {1'b1, {63{1'b0}}};

  logic [3:0]         state_r;
  logic [ADDR_W-1:0]  clr_cnt_r;
  cmd_t               cmd_r;
  logic [5:0]         k_r;
  logic signed [63:0] acc_r;
  logic               sat_r;
  logic signed [64:0] pl_r;
  logic signed [63:0] ph_r;
  logic signed [95:0] p_r;
  logic signed [15:0] rd_q_r;

  logic signed [15:0] mem [STORE_DEPTH];
  logic [5:0]         top_exp_r  [NUM_POLYS];
  logic               nonempty_r [NUM_POLYS];

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic signed [15:0] mem_wdata;
  logic [SLOT_W-1:0]  head_slot;

  logic signed [95:0] p_sum, p_sh;
  logic signed [63:0] prod_sat, term;
  logic signed [64:0] acc_sum;
  logic               prod_ovf, sum_ovf;
  logic signed [63:0] acc_nxt;

  assign head_slot = SLOT_W'(head.slot);
  assign pop       = (state_r == S_IDLE) && !q_empty;
  assign stat.clearing = state_r == S_CLEAR;

  // store access
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ADDR_W'(32'(head.slot) * MAX_DEGREE_TERMS + 32'(head.exp));
    mem_wdata = head.coef;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (pop && head.op == OP_INS && head.exp_ok) begin
      mem_we = 1'b1;
    end
  end

  assign mem_raddr = (state_r == S_QRY) ?
      ADDR_W'(32'(cmd_r.slot) * MAX_DEGREE_TERMS + 32'(cmd_r.exp)) :
      ADDR_W'(32'(cmd_r.slot) * MAX_DEGREE_TERMS + 32'(k_r));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q_r <= mem[mem_raddr];
  end

  // Horner step: floor(acc*x / 2^F) saturated, plus c*2^F saturated
  always_comb begin
    p_sum    = $signed({ph_r, 32'b0}) + $signed({{31{pl_r[64]}}, pl_r});
    p_sh     = p_r >>> FRAC_BITS;
    prod_ovf = !((&p_sh[95:63]) || !(|p_sh[95:63]));
    prod_sat = prod_ovf ? (p_sh[95] ? I64_MIN : I64_MAX) : p_sh[63:0];
    term     = $signed({{48{rd_q_r[15]}}, rd_q_r}) <<< FRAC_BITS;
    acc_sum  = {prod_sat[63], prod_sat} + {term[63], term};
    sum_ovf  = acc_sum[64] != acc_sum[63];
    acc_nxt  = sum_ovf ? (acc_sum[64] ? I64_MIN : I64_MAX) : acc_sum[63:0];
  end

  always_ff @(posedge clk) begin
    pl_r <= $signed({1'b0, acc_r[31:0]}) * cmd_r.point;
    ph_r <= $signed(acc_r[63:32]) * cmd_r.point;
    p_r  <= p_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_POLYS; i++) begin
        top_exp_r[i]  <= '0;
        nonempty_r[i] <= 1'b0;
      end
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (32'(clr_cnt_r) == STORE_DEPTH - 1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            cmd_r               <= head;
            out_value           <= '0;
            out_coefficient_out <= '0;
            out_status          <= ST_OK;
            case (head.op)
              OP_INS: begin
                out_valid <= 1'b1;
                if (head.exp_ok) begin
                  if (!nonempty_r[head_slot] || head.exp > top_exp_r[head_slot]) begin
                    top_exp_r[head_slot] <= head.exp;
                  end
                  nonempty_r[head_slot] <= 1'b1;
                end
              end
              OP_EVAL: begin
                if (nonempty_r[head_slot]) begin
                  k_r     <= top_exp_r[head_slot];
                  acc_r   <= '0;
                  sat_r   <= 1'b0;
                  state_r <= S_RD;
                end else begin
                  out_valid <= 1'b1;
                end
              end
              OP_QRY: begin
                if (head.exp_ok) begin
                  state_r <= S_QRY;
                end else begin
                  out_valid <= 1'b1;
                end
              end
              OP_OOR: begin
                out_valid  <= 1'b1;
                out_status <= ST_RANGE;
              end
              default: begin
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        S_RD:   state_r <= S_MUL1;
        S_MUL1: state_r <= S_MUL2;
        S_MUL2: state_r <= S_SUM;
        S_SUM:  state_r <= S_ACC;
        S_ACC: begin
          acc_r <= acc_nxt;
          sat_r <= sat_r || prod_ovf || sum_ovf;
          if (k_r == '0) begin
            out_valid  <= 1'b1;
            out_value  <= acc_nxt;
            out_status <= (sat_r || prod_ovf || sum_ovf) ? ST_SAT : ST_OK;
            state_r    <= S_IDLE;
          end else begin
            k_r     <= k_r - 1'b1;
            state_r <= S_RD;
          end
        end
        S_QRY:  state_r <= S_QOUT;
        S_QOUT: begin
          out_valid           <= 1'b1;
          out_coefficient_out <= rd_q_r;
          state_r             <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/polynomial_store_horner_eval_unit.sv -----
`default_nettype none
// Polynomial store with Horner evaluation.
// Input words: pulse start with in_mode/in_poly_index/in_exponent/
// in_term_coefficient/in_point; the word is taken when start is high and
// busy is low. Modes: insert a coefficient, evaluate a slot at a Q16.16
// point, query one coefficient. Every word gives exactly one result word.
// Result words: out_valid is high for one cycle with out_value (Q47.16,
// saturated), out_coefficient_out and out_status; the receiver cannot stall.
// Config: cfg_we/cfg_wdata write polys_in_use; write only while idle.
// Accepted words pass a classifier and a two-entry queue, so the front takes
// new words while the executor works; busy rises when the queue is full.
// Insert, out-of-range and empty-slot words are answered from idle; a query
// reads the store; evaluate loops a read / two half multiplies / 96-bit sum /
// shift-saturate-add step for each exponent from top_exponent down to zero.
// Reset: synchronous, rst_n low. After reset a clearing pass writes zero
// to all NUM_POLYS*MAX_DEGREE_TERMS store entries (1024 by default),
// one per cycle, with busy held high; config writes are taken meanwhile.
module polynomial_store_horner_eval_unit #(
  parameter int NUM_POLYS        = pshe_pkg::NUM_POLYS_DEF,
  parameter int MAX_DEGREE_TERMS = pshe_pkg::MAX_DEGREE_TERMS_DEF,
  parameter int FRAC_BITS        = pshe_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_mode,
  input  wire logic [3:0]         in_poly_index,
  input  wire logic [5:0]         in_exponent,
  input  wire logic signed [15:0] in_term_coefficient,
  input  wire logic signed [31:0] in_point,
  output logic                    out_valid,
  output logic signed [63:0]      out_value,
  output logic signed [15:0]      out_coefficient_out,
  output logic [1:0]              out_status,
  input  wire logic               cfg_we,
  input  wire logic [4:0]         cfg_wdata
);
  import pshe_pkg::*;
  `include "polynomial_store_horner_eval_unit_assert.svh"

  logic       push, pop;
  cmd_t       push_word, head;
  q_stat_t    q_stat;
  back_stat_t b_stat;

  // busy while clearing the store or when the queue cannot take a word
  assign busy = q_stat.full || b_stat.clearing;

  pshe_front #(
    .NUM_POLYS        (NUM_POLYS),
    .MAX_DEGREE_TERMS (MAX_DEGREE_TERMS)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_poly_index       (in_poly_index),
    .in_exponent         (in_exponent),
    .in_term_coefficient (in_term_coefficient),
    .in_point            (in_point),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .push                (push),
    .push_word           (push_word)
  );

  pshe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  pshe_back #(
    .NUM_POLYS        (NUM_POLYS),
    .MAX_DEGREE_TERMS (MAX_DEGREE_TERMS),
    .FRAC_BITS        (FRAC_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head                (head),
    .q_empty             (q_stat.empty),
    .pop                 (pop),
    .stat                (b_stat),
    .out_valid           (out_valid),
    .out_value           (out_value),
    .out_coefficient_out (out_coefficient_out),
    .out_status          (out_status)
  );

  `PSHE_ASSERT_IMPLIES(a_clear_blocks, b_stat.clearing, busy && !out_valid)
  `PSHE_ASSERT_IMPLIES(a_range_zero, out_valid && out_status == ST_RANGE,
                       out_value == '0 && out_coefficient_out == '0)
  `PSHE_ASSERT_IMPLIES(a_coef_ok, out_valid && out_coefficient_out != '0,
                       out_status == ST_OK && out_value == '0)
  `PSHE_ASSERT_NEXT(a_pop_nonempty, pop, !q_stat.full)

endmodule
`default_nettype wire
